/* hdl/line_line_intersection_assert.svh */
// ----------------------------------------------------------------------------
// line_line_intersection_assert.svh
// Assertion macros used by the line_line_intersection RTL.
// ----------------------------------------------------------------------------
`ifndef LINE_LINE_INTERSECTION_ASSERT_SVH
`define LINE_LINE_INTERSECTION_ASSERT_SVH

// plain property, checked on every clock edge outside reset
`define LLI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// implication, same cycle
`define LLI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hdl/lli_pkg.sv */
// ----------------------------------------------------------------------------
// lli_pkg
// Shared constants, widths and the stage control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package lli_pkg;

  localparam int LLI_COEF_BITS = 16;
  localparam int LLI_FRAC_BITS = 16;
  localparam int LLI_CW        = 32;   // constant term width
  localparam int LLI_QW        = 32;   // coordinate width

  typedef struct packed {
    logic valid;
    logic zero;    // determinant is zero
    logic neg_x;
    logic neg_y;
    logic ovf_x;   // quotient >= 2^32
    logic ovf_y;
  } lli_ctl_t;

  function automatic int lli_num_w(input int cw);
    return cw + LLI_CW + 1;
  endfunction

  function automatic int lli_den_w(input int cw);
    return 2 * cw + 1;
  endfunction

  // remainder width: holds num << frac and den << (QW-1)
  function automatic int lli_rem_w(input int cw, input int fw);
    int a;
    int b;
    a = lli_num_w(cw) + fw;
    b = lli_den_w(cw) + LLI_QW;
    return ((a > b) ? a : b) + 1;
  endfunction

endpackage

`default_nettype wire

/* hdl/line_line_intersection.sv */
// ----------------------------------------------------------------------------
// line_line_intersection
// Intersection of two lines A*x+B*y+C=0 by Cramer's rule, signed fixed point.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                   | Dir | Transfer
//  --------+-----------------------------------------+-----+-------------------
//  in      | in_line1_a/b/c, in_line2_a/b/c          | in  | in_valid & in_ready
//  out     | out_cross_x/y, out_found, out_clipped   | out | out_valid & out_ready
//
//  One transfer per cycle unless out stalls; pipeline: three front stages
//  (products, differences, magnitudes), 32 divider stages (one quotient bit
//  each, x and y side by side) and the saturating output register.
//  rst_n is synchronous; it clears all valid bits, payload is not reset.
//  A stall on out holds the whole pipeline; in_ready drops only while the
//  output register holds a result that is not taken.
//
`default_nettype none

module line_line_intersection
  import lli_pkg::*;
#(
  parameter int COEF_BITS = LLI_COEF_BITS,
  parameter int FRAC_BITS = LLI_FRAC_BITS
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  signed [COEF_BITS-1:0] in_line1_a,
  input  wire  signed [COEF_BITS-1:0] in_line1_b,
  input  wire  signed [LLI_CW-1:0]    in_line1_c,
  input  wire  signed [COEF_BITS-1:0] in_line2_a,
  input  wire  signed [COEF_BITS-1:0] in_line2_b,
  input  wire  signed [LLI_CW-1:0]    in_line2_c,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic signed [LLI_QW-1:0]    out_cross_x,
  output logic signed [LLI_QW-1:0]    out_cross_y,
  output logic                        out_found,
  output logic                        out_clipped
);

  localparam int SW    = lli_rem_w(COEF_BITS, FRAC_BITS);
  localparam int HW    = lli_den_w(COEF_BITS);
  localparam int NSTEP = LLI_QW;

  localparam logic [LLI_QW-1:0] POS_LIM = {1'b0, {(LLI_QW-1){1'b1}}};
  localparam logic [LLI_QW-1:0] NEG_LIM = {1'b1, {(LLI_QW-1){1'b0}}};

  // whole pipeline moves when the output register is free or being drained
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // divider chain: index 0 is the front's output
  lli_ctl_t          ctl_s   [0:NSTEP];
  logic [SW-1:0]     rem_x_s [0:NSTEP];
  logic [SW-1:0]     rem_y_s [0:NSTEP];
  logic [LLI_QW-1:0] q_x_s   [0:NSTEP];
  logic [LLI_QW-1:0] q_y_s   [0:NSTEP];
  logic [HW-1:0]     den_s   [0:NSTEP];

  lli_front #(
    .COEF_BITS (COEF_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .a1       (in_line1_a),
    .b1       (in_line1_b),
    .c1       (in_line1_c),
    .a2       (in_line2_a),
    .b2       (in_line2_b),
    .c2       (in_line2_c),
    .ctl_o    (ctl_s[0]),
    .rem_x_o  (rem_x_s[0]),
    .rem_y_o  (rem_y_s[0]),
    .den_o    (den_s[0])
  );

  assign q_x_s[0] = '0;
  assign q_y_s[0] = '0;

  // quotient bits MSB first
  for (genvar k = 0; k < NSTEP; k++) begin : g_div
    lli_div_step #(
      .COEF_BITS (COEF_BITS),
      .FRAC_BITS (FRAC_BITS),
      .BIT_POS   (NSTEP - 1 - k)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .ctl_i   (ctl_s[k]),
      .rem_x_i (rem_x_s[k]),
      .rem_y_i (rem_y_s[k]),
      .q_x_i   (q_x_s[k]),
      .q_y_i   (q_y_s[k]),
      .den_i   (den_s[k]),
      .ctl_o   (ctl_s[k+1]),
      .rem_x_o (rem_x_s[k+1]),
      .rem_y_o (rem_y_s[k+1]),
      .q_x_o   (q_x_s[k+1]),
      .q_y_o   (q_y_s[k+1]),
      .den_o   (den_s[k+1])
    );
  end

  // output stage: saturate against the signed bound, restore sign,
  // force zeros for parallel lines
  lli_ctl_t          ctl_f;
  logic [LLI_QW-1:0] lim_x, lim_y, mag_x, mag_y;
  logic              clip_x, clip_y;
  logic              out_valid_r;
  logic [LLI_QW-1:0] cross_x_r, cross_y_r, cross_x_nxt, cross_y_nxt;
  logic              found_r, clipped_r, found_nxt, clipped_nxt;

  assign ctl_f = ctl_s[NSTEP];

  always_comb begin
    lim_x  = ctl_f.neg_x ? NEG_LIM : POS_LIM;
    lim_y  = ctl_f.neg_y ? NEG_LIM : POS_LIM;
    clip_x = ctl_f.ovf_x || (q_x_s[NSTEP] > lim_x);
    clip_y = ctl_f.ovf_y || (q_y_s[NSTEP] > lim_y);
    mag_x  = clip_x ? lim_x : q_x_s[NSTEP];
    mag_y  = clip_y ? lim_y : q_y_s[NSTEP];
    if (ctl_f.zero) begin
      cross_x_nxt = '0;
      cross_y_nxt = '0;
      found_nxt   = 1'b0;
      clipped_nxt = 1'b0;
    end else begin
      cross_x_nxt = ctl_f.neg_x ? (~mag_x + 1'b1) : mag_x;
      cross_y_nxt = ctl_f.neg_y ? (~mag_y + 1'b1) : mag_y;
      found_nxt   = 1'b1;
      clipped_nxt = clip_x || clip_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_f.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cross_x_r <= cross_x_nxt;
      cross_y_r <= cross_y_nxt;
      found_r   <= found_nxt;
      clipped_r <= clipped_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_cross_x = cross_x_r;
  assign out_cross_y = cross_y_r;
  assign out_found   = found_r;
  assign out_clipped = clipped_r;

`include "line_line_intersection_assert.svh"

  // parallel lines give an all-zero result
  `LLI_ASSERT_IMP(a_parallel_zero, out_valid && !out_found,
    (out_cross_x == '0) && (out_cross_y == '0) && !out_clipped,
    "parallel result not zero")

  // a clipped result has a coordinate at a bound
  `LLI_ASSERT_IMP(a_clip_bound, out_valid && out_clipped,
    out_found && ((out_cross_x == POS_LIM) || (out_cross_x == NEG_LIM) ||
    (out_cross_y == POS_LIM) || (out_cross_y == NEG_LIM)),
    "clipped without saturated coordinate")

  // a held result stalls the whole pipe, front included
  `LLI_ASSERT_IMP(a_stall_hold, out_valid && !out_ready,
    !in_ready && !en, "pipeline advanced under stall")

endmodule

`default_nettype wire

/* hdl/lli_front.sv */
// ----------------------------------------------------------------------------
// lli_front
// Products, determinant and numerators, then magnitudes and overflow check.
// ----------------------------------------------------------------------------
`default_nettype none

module lli_front
  import lli_pkg::*;
#(
  parameter int COEF_BITS = LLI_COEF_BITS,
  parameter int FRAC_BITS = LLI_FRAC_BITS
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire                                        en,
  input  wire                                        in_valid,
  input  wire  signed [COEF_BITS-1:0]                a1,
  input  wire  signed [COEF_BITS-1:0]                b1,
  input  wire  signed [LLI_CW-1:0]                   c1,
  input  wire  signed [COEF_BITS-1:0]                a2,
  input  wire  signed [COEF_BITS-1:0]                b2,
  input  wire  signed [LLI_CW-1:0]                   c2,
  output lli_ctl_t                                   ctl_o,
  output logic [lli_rem_w(COEF_BITS, FRAC_BITS)-1:0] rem_x_o,
  output logic [lli_rem_w(COEF_BITS, FRAC_BITS)-1:0] rem_y_o,
  output logic [lli_den_w(COEF_BITS)-1:0]            den_o
);

  localparam int PW   = 2 * COEF_BITS;
  localparam int CPW  = COEF_BITS + LLI_CW;
  localparam int NUMW = lli_num_w(COEF_BITS);
  localparam int HW   = lli_den_w(COEF_BITS);
  localparam int SW   = lli_rem_w(COEF_BITS, FRAC_BITS);
  localparam int SH   = LLI_QW - FRAC_BITS;

  // stage 1: products
  logic                  v1_r;
  logic signed [PW-1:0]  p_a1b2_r, p_b1a2_r;
  logic signed [CPW-1:0] p_b1c2_r, p_b2c1_r, p_c1a2_r, p_a1c2_r;

  // stage 2: differences
  logic                   v2_r;
  logic signed [HW-1:0]   h_r;
  logic signed [NUMW-1:0] nx_r, ny_r;

  // stage 3: magnitudes
  lli_ctl_t        ctl3_r, ctl3_nxt;
  logic [SW-1:0]   rem_x_r, rem_y_r;
  logic [HW-1:0]   den_r;
  logic [HW-1:0]   h_mag;
  logic [NUMW-1:0] nx_mag, ny_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ctl3_r <= '0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      ctl3_r <= ctl3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_a1b2_r <= a1 * b2;
      p_b1a2_r <= b1 * a2;
      p_b1c2_r <= b1 * c2;
      p_b2c1_r <= b2 * c1;
      p_c1a2_r <= c1 * a2;
      p_a1c2_r <= a1 * c2;
      h_r      <= HW'(p_a1b2_r) - HW'(p_b1a2_r);
      nx_r     <= NUMW'(p_b1c2_r) - NUMW'(p_b2c1_r);
      ny_r     <= NUMW'(p_c1a2_r) - NUMW'(p_a1c2_r);
      rem_x_r  <= SW'(nx_mag) << FRAC_BITS;
      rem_y_r  <= SW'(ny_mag) << FRAC_BITS;
      den_r    <= h_mag;
    end
  end

  always_comb begin
    h_mag  = h_r[HW-1] ? HW'(-h_r) : HW'(h_r);
    nx_mag = nx_r[NUMW-1] ? NUMW'(-nx_r) : NUMW'(nx_r);
    ny_mag = ny_r[NUMW-1] ? NUMW'(-ny_r) : NUMW'(ny_r);
    ctl3_nxt.valid = v2_r;
    ctl3_nxt.zero  = (h_r == '0);
    ctl3_nxt.neg_x = nx_r[NUMW-1] ^ h_r[HW-1];
    ctl3_nxt.neg_y = ny_r[NUMW-1] ^ h_r[HW-1];
    // quotient >= 2^32 exactly when (num >> (32-frac)) >= den
    ctl3_nxt.ovf_x = (SW'(nx_mag) >> SH) >= SW'(h_mag);
    ctl3_nxt.ovf_y = (SW'(ny_mag) >> SH) >= SW'(h_mag);
  end

  assign ctl_o   = ctl3_r;
  assign rem_x_o = rem_x_r;
  assign rem_y_o = rem_y_r;
  assign den_o   = den_r;

endmodule

`default_nettype wire

/* hdl/lli_div_step.sv */
// ----------------------------------------------------------------------------
// lli_div_step
// One restoring division stage: one quotient bit for x and for y.
// ----------------------------------------------------------------------------
`default_nettype none

module lli_div_step
  import lli_pkg::*;
#(
  parameter int COEF_BITS = LLI_COEF_BITS,
  parameter int FRAC_BITS = LLI_FRAC_BITS,
  parameter int BIT_POS   = LLI_QW - 1
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire                                        en,
  input  lli_ctl_t                                   ctl_i,
  input  wire  [lli_rem_w(COEF_BITS, FRAC_BITS)-1:0] rem_x_i,
  input  wire  [lli_rem_w(COEF_BITS, FRAC_BITS)-1:0] rem_y_i,
  input  wire  [LLI_QW-1:0]                          q_x_i,
  input  wire  [LLI_QW-1:0]                          q_y_i,
  input  wire  [lli_den_w(COEF_BITS)-1:0]            den_i,
  output lli_ctl_t                                   ctl_o,
  output logic [lli_rem_w(COEF_BITS, FRAC_BITS)-1:0] rem_x_o,
  output logic [lli_rem_w(COEF_BITS, FRAC_BITS)-1:0] rem_y_o,
  output logic [LLI_QW-1:0]                          q_x_o,
  output logic [LLI_QW-1:0]                          q_y_o,
  output logic [lli_den_w(COEF_BITS)-1:0]            den_o
);

  localparam int SW = lli_rem_w(COEF_BITS, FRAC_BITS);
  localparam int HW = lli_den_w(COEF_BITS);

  lli_ctl_t          ctl_r;
  logic [SW-1:0]     rem_x_r, rem_y_r, rem_x_nxt, rem_y_nxt, dsh;
  logic [LLI_QW-1:0] q_x_r, q_y_r, q_x_nxt, q_y_nxt;
  logic [HW-1:0]     den_r;
  logic              ge_x, ge_y;

  always_comb begin
    dsh  = SW'(den_i) << BIT_POS;
    ge_x = (rem_x_i >= dsh);
    ge_y = (rem_y_i >= dsh);
    rem_x_nxt = ge_x ? (rem_x_i - dsh) : rem_x_i;
    rem_y_nxt = ge_y ? (rem_y_i - dsh) : rem_y_i;
    q_x_nxt = q_x_i;
    q_y_nxt = q_y_i;
    q_x_nxt[BIT_POS] = ge_x;
    q_y_nxt[BIT_POS] = ge_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
      q_x_r   <= q_x_nxt;
      q_y_r   <= q_y_nxt;
      den_r   <= den_i;
    end
  end

  assign ctl_o   = ctl_r;
  assign rem_x_o = rem_x_r;
  assign rem_y_o = rem_y_r;
  assign q_x_o   = q_x_r;
  assign q_y_o   = q_y_r;
  assign den_o   = den_r;

endmodule

`default_nettype wire
